@@ rtl/ptg_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and arithmetic helpers for the pan/tilt path generator
// no dependencies; every rtl file refers to it by scoped names
package ptg_pkg;

  // fixed-point formats
  localparam int PHASE_BITS     = 12;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int POS_W          = 12;
  localparam int DMX_BITS       = 8;

  // sine evaluation: Horner steps of the series in Q30
  localparam int HORNER_STEPS = 7;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [30:0] PIHALF_Q30   = 31'd1686629713;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // rotation degrees to turn fraction: 2^32/360 = TURN_PER_DEG + 256/360
  localparam logic [23:0] TURN_PER_DEG    = 24'd11930464;
  localparam logic [16:0] RECIP_360       = 17'd93206;
  localparam int          RECIP_360_SHIFT = 25;
  localparam logic [8:0]  DEG_TURN        = 9'd360;
  localparam logic [16:0] DEG_HALF        = 17'd180;

  // pipeline depths
  localparam int FRONT_LAT = 3;
  localparam int SIN_LAT   = 2 + 3 * HORNER_STEPS + 2;
  localparam int SHAPE_LAT = 3;
  localparam int ROT_LAT   = 4;
  localparam int MAP_LAT   = 1 + DMX_BITS;
  localparam int PIPE_LAT  = FRONT_LAT + SIN_LAT + SHAPE_LAT + ROT_LAT + MAP_LAT;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << TRIG_FRAC_BITS;

  typedef enum logic [2:0] {
    SHAPE_CIRCLE  = 3'd0,
    SHAPE_SQUARE  = 3'd1,
    SHAPE_LEAF    = 3'd2,
    SHAPE_LINE    = 3'd3,
    SHAPE_DIAMOND = 3'd4,
    SHAPE_FIGURE8 = 3'd5
  } shape_t;

  typedef enum logic [2:0] {
    REG_SHAPE       = 3'd0,
    REG_WIDTH       = 3'd1,
    REG_HEIGHT      = 3'd2,
    REG_PAN_OFFSET  = 3'd3,
    REG_TILT_OFFSET = 3'd4,
    REG_PAN_TRAVEL  = 3'd5,
    REG_TILT_TRAVEL = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_a;
    logic signed [TRIG_W-1:0] cos_a;
  } trig_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_r;
    logic signed [TRIG_W-1:0] sin_r;
  } rot_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
  } point_t;

  // Horner divisors, innermost term first
  function automatic logic [7:0] horner_div(input int k);
    logic [7:0] d;
    case (k)
      0: d = 8'd210;
      1: d = 8'd156;
      2: d = 8'd110;
      3: d = 8'd72;
      4: d = 8'd42;
      5: d = 8'd20;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), quotient is exact or one low
  function automatic logic [29:0] horner_recip(input int k);
    logic [29:0] m;
    case (k)
      0: m = 30'd20452225;
      1: m = 30'd27531841;
      2: m = 30'd39045157;
      3: m = 30'd59652323;
      4: m = 30'd102261126;
      5: m = 30'd214748364;
      default: m = 30'd715827882;
    endcase
    return m;
  endfunction

  // product rounded half away from zero to TRIG_FRAC_BITS fraction bits
  function automatic logic signed [TRIG_W-1:0] mul_q(input logic signed [TRIG_W-1:0] a,
                                                      input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    logic [2*TRIG_W-1:0] mag;
    logic [2*TRIG_W-1:0] rnd;
    p   = a * b;
    mag = p[2*TRIG_W-1] ? (2*TRIG_W)'(-p) : (2*TRIG_W)'(p);
    rnd = (mag + ((2*TRIG_W)'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    return p[2*TRIG_W-1] ? -$signed(TRIG_W'(rnd)) : $signed(TRIG_W'(rnd));
  endfunction

endpackage

@@ rtl/pan_tilt_path_generator.sv @@
`timescale 1ns / 1ps
// pan/tilt path generator top: config registers, angle front end, sine units,
// shape, rotation and DMX mapping stages; depends on ptg_pkg and ptg_* modules
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per sample: phase, a
//   fraction of one turn in 1/4096 steps, and rotation in whole degrees.
//   Output channel (out_valid/out_ready) returns one beat per input beat with
//   the pan_value and tilt_value DMX bytes, in input order.
//   Configuration is a write port (cfg_we, cfg_index, cfg_data); write only
//   while no samples are in flight.
//   The sine series with its seven Horner steps of three stages each makes up
//   most of the pipeline. One sample is taken every cycle while the output
//   is not stalled.
//   The whole pipeline advances together: when out_valid is high and
//   out_ready low, every stage holds and in_ready drops in the same cycle.
//   Reset empties the pipeline and loads the default configuration: circle,
//   30 by 30 degrees, no offsets, 360 degrees pan and 150 degrees tilt travel.
module pan_tilt_path_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ptg_pkg::PHASE_BITS-1:0]      phase,
  input  logic [8:0]                          rotation,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ptg_pkg::DMX_BITS-1:0]        pan_value,
  output logic [ptg_pkg::DMX_BITS-1:0]        tilt_value,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [9:0]                          cfg_data
);

  logic [2:0]        path_shape;
  logic [8:0]        path_width, path_height;
  logic signed [8:0] pan_offset, tilt_offset;
  logic [9:0]        pan_travel_degrees, tilt_travel_degrees;

  logic en;
  logic vld [0:ptg_pkg::PIPE_LAT-1];

  logic [ptg_pkg::PHASE_BITS-1:0] ph0, ph1, ph2;
  logic [8:0]  rot0;
  logic [8:0]  rdeg;
  logic [16:0] n1, n_q;
  logic [33:0] m1;
  logic [31:0] base1, base_q;
  logic [8:0]  q0_q;
  logic [16:0] r2;
  logic [8:0]  q2;
  logic [31:0] ra_q;

  logic [31:0] a_ph, ang_sin, ang_cos, ang_cr;
  ptg_pkg::trig_t  trig;
  ptg_pkg::rot_t   rot_s;
  ptg_pkg::rot_t   rot_d [0:ptg_pkg::SHAPE_LAT-1];
  logic [ptg_pkg::PHASE_BITS-1:0] ph_d [0:ptg_pkg::SIN_LAT-1];
  ptg_pkg::point_t pt;
  logic signed [ptg_pkg::POS_W-1:0] pan_pos, tilt_pos;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      path_shape          <= ptg_pkg::SHAPE_CIRCLE;
      path_width          <= 9'd30;
      path_height         <= 9'd30;
      pan_offset          <= '0;
      tilt_offset         <= '0;
      pan_travel_degrees  <= 10'd360;
      tilt_travel_degrees <= 10'd150;
    end else if (cfg_we) begin
      case (cfg_index)
        ptg_pkg::REG_SHAPE:       path_shape          <= cfg_data[2:0];
        ptg_pkg::REG_WIDTH:       path_width          <= cfg_data[8:0];
        ptg_pkg::REG_HEIGHT:      path_height         <= cfg_data[8:0];
        ptg_pkg::REG_PAN_OFFSET:  pan_offset          <= $signed(cfg_data[8:0]);
        ptg_pkg::REG_TILT_OFFSET: tilt_offset         <= $signed(cfg_data[8:0]);
        ptg_pkg::REG_PAN_TRAVEL:  pan_travel_degrees  <= cfg_data;
        ptg_pkg::REG_TILT_TRAVEL: tilt_travel_degrees <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance and valid bits
  assign en        = !vld[ptg_pkg::PIPE_LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[ptg_pkg::PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptg_pkg::PIPE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < ptg_pkg::PIPE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (en) begin
      ph0  <= phase;
      rot0 <= rotation;
    end
  end

  // rotation degrees to turn fraction, first half: reduce and estimate
  always_comb begin
    rdeg  = (rot0 >= ptg_pkg::DEG_TURN) ? rot0 - ptg_pkg::DEG_TURN : rot0;
    n1    = {rdeg, 8'b0} + ptg_pkg::DEG_HALF;
    m1    = 34'(n1) * 34'(ptg_pkg::RECIP_360);
    base1 = 32'(rdeg) * 32'(ptg_pkg::TURN_PER_DEG);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_q    <= n1;
      q0_q   <= m1[ptg_pkg::RECIP_360_SHIFT+8:ptg_pkg::RECIP_360_SHIFT];
      base_q <= base1;
      ph1    <= ph0;
    end
  end

  // second half: correct the quotient and add
  always_comb begin
    r2 = n_q - 17'(17'(q0_q) * 17'(ptg_pkg::DEG_TURN));
    q2 = q0_q + 9'(r2 >= 17'(ptg_pkg::DEG_TURN));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_q <= base_q + 32'(q2);
      ph2  <= ph1;
    end
  end

  // sine unit angles
  always_comb begin
    a_ph    = 32'(ph2) << (32 - ptg_pkg::PHASE_BITS);
    ang_sin = (path_shape == ptg_pkg::SHAPE_FIGURE8) ? a_ph << 1 : a_ph;
    ang_cos = a_ph + ptg_pkg::QUARTER_TURN;
    ang_cr  = ra_q + ptg_pkg::QUARTER_TURN;
  end

  ptg_sine u_sin_a (.clk(clk), .en(en), .angle(ang_sin), .value(trig.sin_a));
  ptg_sine u_cos_a (.clk(clk), .en(en), .angle(ang_cos), .value(trig.cos_a));
  ptg_sine u_cos_r (.clk(clk), .en(en), .angle(ang_cr),  .value(rot_s.cos_r));
  ptg_sine u_sin_r (.clk(clk), .en(en), .angle(ra_q),    .value(rot_s.sin_r));

  // phase follows the sine units, rotation terms follow the shape stages
  always_ff @(posedge clk) begin
    if (en) begin
      ph_d[0] <= ph2;
      for (int i = 1; i < ptg_pkg::SIN_LAT; i++) begin
        ph_d[i] <= ph_d[i-1];
      end
      rot_d[0] <= rot_s;
      for (int i = 1; i < ptg_pkg::SHAPE_LAT; i++) begin
        rot_d[i] <= rot_d[i-1];
      end
    end
  end

  ptg_shape u_shape (
    .clk   (clk),
    .en    (en),
    .shape (path_shape),
    .ph    (ph_d[ptg_pkg::SIN_LAT-1]),
    .trig  (trig),
    .pt    (pt)
  );

  ptg_rotate u_rotate (
    .clk         (clk),
    .en          (en),
    .pt          (pt),
    .rot         (rot_d[ptg_pkg::SHAPE_LAT-1]),
    .path_width  (path_width),
    .path_height (path_height),
    .pan_offset  (pan_offset),
    .tilt_offset (tilt_offset),
    .pan_pos     (pan_pos),
    .tilt_pos    (tilt_pos)
  );

  ptg_map u_map_pan (
    .clk    (clk),
    .en     (en),
    .pos    (pan_pos),
    .travel (pan_travel_degrees),
    .value  (pan_value)
  );

  ptg_map u_map_tilt (
    .clk    (clk),
    .en     (en),
    .pos    (tilt_pos),
    .travel (tilt_travel_degrees),
    .value  (tilt_value)
  );

endmodule

@@ rtl/ptg_sine.sv @@
`timescale 1ns / 1ps
// pipelined sine of a 32-bit turn fraction: quadrant fold, Q30 series by Horner
// steps with reciprocal division, rounding to Q1.15; depends on ptg_pkg
module ptg_sine (
  input  logic                                clk,
  input  logic                                en,
  input  logic [31:0]                         angle,
  output logic signed [ptg_pkg::TRIG_W-1:0]   value
);

  logic [30:0] t0;
  logic [61:0] th_prod;
  logic [30:0] theta0;
  logic        sgn0;
  logic [61:0] x2_prod;

  logic [31:0] x2_q [0:ptg_pkg::HORNER_STEPS];
  logic [30:0] y_q  [0:ptg_pkg::HORNER_STEPS];
  logic [30:0] th_q [0:ptg_pkg::HORNER_STEPS];
  logic        sg_q [0:ptg_pkg::HORNER_STEPS];

  logic [61:0] fin_prod;
  logic [30:0] s_f;
  logic        sg_f;
  logic [31:0] rnd;
  logic [ptg_pkg::TRIG_W-1:0] mag;

  // fold into the first quadrant and scale by pi/2
  always_comb begin
    t0 = {1'b0, angle[29:0]};
    if (angle[30]) begin
      t0 = ptg_pkg::Q30_ONE - {1'b0, angle[29:0]};
    end
    th_prod = 62'(t0) * 62'(ptg_pkg::PIHALF_Q30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta0 <= th_prod[60:30];
      sgn0   <= angle[31];
    end
  end

  // theta squared
  assign x2_prod = 62'(theta0) * 62'(theta0);

  always_ff @(posedge clk) begin
    if (en) begin
      x2_q[0] <= x2_prod[61:30];
      y_q[0]  <= ptg_pkg::Q30_ONE;
      th_q[0] <= theta0;
      sg_q[0] <= sgn0;
    end
  end

  // one Horner step every three stages: multiply, reciprocal, correction
  for (genvar k = 0; k < ptg_pkg::HORNER_STEPS; k++) begin : g_step
    logic [62:0] prod_a;
    logic [31:0] p_a, x2_a;
    logic [30:0] th_a;
    logic        sg_a;
    logic [61:0] prod_b;
    logic [29:0] q0_b;
    logic [31:0] p_b, x2_b;
    logic [30:0] th_b;
    logic        sg_b;
    logic [31:0] qd_c, r_c;
    logic [29:0] q_c;

    assign prod_a = 63'(x2_q[k]) * 63'(y_q[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        p_a  <= prod_a[61:30];
        x2_a <= x2_q[k];
        th_a <= th_q[k];
        sg_a <= sg_q[k];
      end
    end

    assign prod_b = 62'(p_a) * 62'(ptg_pkg::horner_recip(k));

    always_ff @(posedge clk) begin
      if (en) begin
        q0_b <= prod_b[61:32];
        p_b  <= p_a;
        x2_b <= x2_a;
        th_b <= th_a;
        sg_b <= sg_a;
      end
    end

    // remainder check lifts the quotient by one where needed
    always_comb begin
      qd_c = 32'(q0_b) * 32'(ptg_pkg::horner_div(k));
      r_c  = p_b - qd_c;
      q_c  = q0_b + 30'(r_c >= 32'(ptg_pkg::horner_div(k)));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        y_q[k+1]  <= ptg_pkg::Q30_ONE - {1'b0, q_c};
        x2_q[k+1] <= x2_b;
        th_q[k+1] <= th_b;
        sg_q[k+1] <= sg_b;
      end
    end
  end

  // final multiply by theta
  assign fin_prod = 62'(th_q[ptg_pkg::HORNER_STEPS]) * 62'(y_q[ptg_pkg::HORNER_STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      s_f  <= fin_prod[60:30];
      sg_f <= sg_q[ptg_pkg::HORNER_STEPS];
    end
  end

  // round half up to Q1.15 and apply the sign
  always_comb begin
    rnd = 32'(s_f) + (32'(1) << (29 - ptg_pkg::TRIG_FRAC_BITS));
    mag = rnd[31:30-ptg_pkg::TRIG_FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= sg_f ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

@@ rtl/ptg_shape.sv @@
`timescale 1ns / 1ps
// unit point of the selected path shape, three stages of Q1.15 products
// depends on ptg_pkg
module ptg_shape (
  input  logic                              clk,
  input  logic                              en,
  input  logic [2:0]                        shape,
  input  logic [ptg_pkg::PHASE_BITS-1:0]    ph,
  input  ptg_pkg::trig_t                    trig,
  output ptg_pkg::point_t                   pt
);

  logic                               neg_sin;
  logic signed [ptg_pkg::TRIG_W-1:0]  sn;
  logic [1:0]                         quarter;
  logic [ptg_pkg::PHASE_BITS-3:0]     u;
  logic signed [ptg_pkg::TRIG_W-1:0]  lin;
  logic signed [ptg_pkg::TRIG_W-1:0]  sqx, sqy;

  logic signed [ptg_pkg::TRIG_W-1:0]  sn1, ca1, ss1, cc1, sqx1, sqy1;
  logic signed [ptg_pkg::TRIG_W-1:0]  sn2, ca2, p2, p3, sqx2, sqy2;
  logic signed [ptg_pkg::TRIG_W-1:0]  leaf_x;
  ptg_pkg::point_t                    pt_next;

  // first stage: shape sign, square edges and the squares
  always_comb begin
    neg_sin = (shape == ptg_pkg::SHAPE_LEAF) || (shape == ptg_pkg::SHAPE_FIGURE8);
    sn      = neg_sin ? -trig.sin_a : trig.sin_a;
    quarter = ph[ptg_pkg::PHASE_BITS-1:ptg_pkg::PHASE_BITS-2];
    u       = ph[ptg_pkg::PHASE_BITS-3:0];
    lin     = $signed((ptg_pkg::TRIG_W)'(
                ((ptg_pkg::PHASE_BITS + ptg_pkg::TRIG_FRAC_BITS - 1)'(u)
                  << (ptg_pkg::TRIG_FRAC_BITS + 1)) >> (ptg_pkg::PHASE_BITS - 2)))
              - ptg_pkg::TRIG_ONE;
    case (quarter)
      2'd0: begin
        sqx = lin;
        sqy = ptg_pkg::TRIG_ONE;
      end
      2'd1: begin
        sqx = ptg_pkg::TRIG_ONE;
        sqy = -lin;
      end
      2'd2: begin
        sqx = -lin;
        sqy = -ptg_pkg::TRIG_ONE;
      end
      default: begin
        sqx = -ptg_pkg::TRIG_ONE;
        sqy = lin;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn1  <= sn;
      ca1  <= trig.cos_a;
      ss1  <= ptg_pkg::mul_q(sn, sn);
      cc1  <= ptg_pkg::mul_q(trig.cos_a, trig.cos_a);
      sqx1 <= sqx;
      sqy1 <= sqy;
    end
  end

  // second stage: fourth power for the leaf, cubes for the diamond
  always_ff @(posedge clk) begin
    if (en) begin
      p2   <= ptg_pkg::mul_q(ss1, (shape == ptg_pkg::SHAPE_LEAF) ? ss1 : sn1);
      p3   <= ptg_pkg::mul_q(cc1, ca1);
      sn2  <= sn1;
      ca2  <= ca1;
      sqx2 <= sqx1;
      sqy2 <= sqy1;
    end
  end

  // third stage: fifth power and shape select
  always_comb begin
    leaf_x = ptg_pkg::mul_q(p2, sn2);
    case (shape)
      ptg_pkg::SHAPE_CIRCLE: begin
        pt_next.x = sn2;
        pt_next.y = ca2;
      end
      ptg_pkg::SHAPE_SQUARE: begin
        pt_next.x = sqx2;
        pt_next.y = sqy2;
      end
      ptg_pkg::SHAPE_LEAF: begin
        pt_next.x = leaf_x;
        pt_next.y = ca2;
      end
      ptg_pkg::SHAPE_LINE: begin
        pt_next.x = ca2;
        pt_next.y = ca2;
      end
      ptg_pkg::SHAPE_DIAMOND: begin
        pt_next.x = p2;
        pt_next.y = p3;
      end
      ptg_pkg::SHAPE_FIGURE8: begin
        pt_next.x = sn2;
        pt_next.y = ca2;
      end
      default: begin
        pt_next.x = '0;
        pt_next.y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt <= pt_next;
    end
  end

endmodule

@@ rtl/ptg_rotate.sv @@
`timescale 1ns / 1ps
// scale, rotate, round to whole degrees and offset, in four stages
// depends on ptg_pkg
module ptg_rotate (
  input  logic                               clk,
  input  logic                               en,
  input  ptg_pkg::point_t                    pt,
  input  ptg_pkg::rot_t                      rot,
  input  logic [8:0]                         path_width,
  input  logic [8:0]                         path_height,
  input  logic signed [8:0]                  pan_offset,
  input  logic signed [8:0]                  tilt_offset,
  output logic signed [ptg_pkg::POS_W-1:0]   pan_pos,
  output logic signed [ptg_pkg::POS_W-1:0]   tilt_pos
);

  logic signed [9:0]                        w_s, h_s;
  logic signed [ptg_pkg::TRIG_W+9:0]        sx, sy;
  ptg_pkg::rot_t                            rot1;
  logic signed [2*ptg_pkg::TRIG_W+9:0]      pxc, pys, pyc, pxs;
  logic signed [2*ptg_pkg::TRIG_W+10:0]     ax, ay;
  logic [2*ptg_pkg::TRIG_W+10:0]            mag_x, mag_y, rnd_x, rnd_y;
  logic signed [15:0]                       rx, ry;

  assign w_s = $signed({1'b0, path_width});
  assign h_s = $signed({1'b0, path_height});

  // scale by width and height
  always_ff @(posedge clk) begin
    if (en) begin
      sx   <= w_s * pt.x;
      sy   <= h_s * pt.y;
      rot1 <= rot;
    end
  end

  // rotation products
  always_ff @(posedge clk) begin
    if (en) begin
      pxc  <= sx * rot1.cos_r;
      pys  <= sy * rot1.sin_r;
      pyc  <= sy * rot1.cos_r;
      pxs  <= sx * rot1.sin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= (2*ptg_pkg::TRIG_W+11)'(pxc) - (2*ptg_pkg::TRIG_W+11)'(pys);
      ay <= (2*ptg_pkg::TRIG_W+11)'(pyc) + (2*ptg_pkg::TRIG_W+11)'(pxs);
    end
  end

  // round half away from zero, then add the offsets
  always_comb begin
    mag_x = ax[2*ptg_pkg::TRIG_W+10] ? (2*ptg_pkg::TRIG_W+11)'(-ax) : (2*ptg_pkg::TRIG_W+11)'(ax);
    mag_y = ay[2*ptg_pkg::TRIG_W+10] ? (2*ptg_pkg::TRIG_W+11)'(-ay) : (2*ptg_pkg::TRIG_W+11)'(ay);
    rnd_x = (mag_x + ((2*ptg_pkg::TRIG_W+11)'(1) << (2*ptg_pkg::TRIG_FRAC_BITS - 1)))
            >> (2*ptg_pkg::TRIG_FRAC_BITS);
    rnd_y = (mag_y + ((2*ptg_pkg::TRIG_W+11)'(1) << (2*ptg_pkg::TRIG_FRAC_BITS - 1)))
            >> (2*ptg_pkg::TRIG_FRAC_BITS);
    rx = ax[2*ptg_pkg::TRIG_W+10] ? -$signed(16'(rnd_x)) : $signed(16'(rnd_x));
    ry = ay[2*ptg_pkg::TRIG_W+10] ? -$signed(16'(rnd_y)) : $signed(16'(rnd_y));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pan_pos  <= (ptg_pkg::POS_W)'(rx + 16'(pan_offset));
      tilt_pos <= (ptg_pkg::POS_W)'(ry + 16'(tilt_offset));
    end
  end

endmodule

@@ rtl/ptg_map.sv @@
`timescale 1ns / 1ps
// clamps one axis to the fixture travel and maps it onto a DMX byte with a
// one-bit-per-stage restoring divider; depends on ptg_pkg
module ptg_map (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [ptg_pkg::POS_W-1:0]   pos,
  input  logic [9:0]                         travel,
  output logic [ptg_pkg::DMX_BITS-1:0]       value
);

  logic [9:0]         t;
  logic [10:0]        two_t;
  logic signed [13:0] n;
  logic [10:0]        nc;

  logic [18:0] rem_q [0:ptg_pkg::DMX_BITS];
  logic [10:0] d_q   [0:ptg_pkg::DMX_BITS];
  logic [ptg_pkg::DMX_BITS-1:0] q_q [0:ptg_pkg::DMX_BITS];

  // clamp 2v + T into 0..2T and scale by 255
  always_comb begin
    t     = (travel == 10'd0) ? 10'd1 : travel;
    two_t = {t, 1'b0};
    n     = 14'(pos) * 14'sd2 + $signed({4'b0, t});
    if (n < 14'sd0) begin
      nc = '0;
    end else if (n > $signed({3'b0, two_t})) begin
      nc = two_t;
    end else begin
      nc = 11'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= {nc, 8'b0} - 19'(nc);
      d_q[0]   <= two_t;
      q_q[0]   <= '0;
    end
  end

  // quotient bits, most significant first
  for (genvar i = 0; i < ptg_pkg::DMX_BITS; i++) begin : g_div
    logic [18:0] sub;
    logic        take;

    assign sub  = 19'(d_q[i]) << (ptg_pkg::DMX_BITS - 1 - i);
    assign take = rem_q[i] >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1] <= take ? rem_q[i] - sub : rem_q[i];
        d_q[i+1]   <= d_q[i];
        q_q[i+1]   <= {q_q[i][ptg_pkg::DMX_BITS-2:0], take};
      end
    end
  end

  assign value = q_q[ptg_pkg::DMX_BITS];

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for pan_tilt_path_generator: predicts pan/tilt bytes per sample
// depends on ptg_pkg and the rtl top; self-checking, no files or arguments
module tb_top;

  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] phase = '0;
  logic [8:0] rotation = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] pan_value, tilt_value;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  // shadow of the configuration registers
  logic [2:0] shape_q;
  logic [8:0] width_q, height_q;
  logic signed [8:0] pan_off_q, tilt_off_q;
  logic [9:0] pan_trav_q, tilt_trav_q;

  logic [15:0] expected_bytes[$];
  int mismatches = 0;
  bit stall_enable = 1'b1;

  pan_tilt_path_generator u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rounded shift, half away from zero
  function automatic longint rnd_away(longint v, int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 << (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint sine_of_turn(logic [31:0] a);
    logic [63:0] t, th, x2, y, s;
    int divs[7];
    divs = '{210, 156, 110, 72, 42, 20, 6};
    t = {34'd0, a[29:0]};
    if (a[30]) t = (64'd1 << 30) - t;
    th = (t * 64'd1686629713) >> 30;
    x2 = (th * th) >> 30;
    y = 64'd1 << 30;
    for (int i = 0; i < 7; i++) y = (64'd1 << 30) - ((x2 * y) >> 30) / divs[i];
    s = (th * y) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    return a[31] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint cosine_of_turn(logic [31:0] a);
    return sine_of_turn(a + 32'h4000_0000);
  endfunction

  function automatic longint mulq(longint a, longint b);
    return rnd_away(a * b, ptg_pkg::TRIG_FRAC_BITS);
  endfunction

  function automatic logic [7:0] degrees_to_dmx(longint v, logic [9:0] travel);
    longint t, n;
    t = travel == 0 ? 1 : travel;
    n = 2 * v + t;
    if (n < 0) n = 0;
    if (n > 2 * t) n = 2 * t;
    return 8'((n * 255) / (2 * t));
  endfunction

  function automatic logic [15:0] predict_pan_tilt(logic [11:0] ph, logic [8:0] rot);
    logic [31:0] a, ra;
    logic [63:0] rdeg;
    longint x, y, s, s2, c, lin, sx, sy, cr, sr, rx, ry;
    a = {ph, 20'd0};
    rdeg = rot % 360;
    ra = 32'(((rdeg << 32) + 180) / 360);
    x = 0;
    y = 0;
    case (shape_q)
      ptg_pkg::SHAPE_CIRCLE: begin
        x = sine_of_turn(a);
        y = cosine_of_turn(a);
      end
      ptg_pkg::SHAPE_SQUARE: begin
        lin = longint'((64'(ph[9:0]) << 16) >> 10) - 32768;
        case (ph[11:10])
          2'd0: begin x = lin; y = 32768; end
          2'd1: begin x = 32768; y = -lin; end
          2'd2: begin x = -lin; y = -32768; end
          default: begin x = -32768; y = lin; end
        endcase
      end
      ptg_pkg::SHAPE_LEAF: begin
        s = -sine_of_turn(a);
        s2 = mulq(s, s);
        x = mulq(mulq(s2, s2), s);
        y = cosine_of_turn(a);
      end
      ptg_pkg::SHAPE_LINE: begin
        x = cosine_of_turn(a);
        y = x;
      end
      ptg_pkg::SHAPE_DIAMOND: begin
        s = sine_of_turn(a);
        c = cosine_of_turn(a);
        x = mulq(mulq(s, s), s);
        y = mulq(mulq(c, c), c);
      end
      ptg_pkg::SHAPE_FIGURE8: begin
        x = -sine_of_turn(a * 2);
        y = cosine_of_turn(a);
      end
      default: ;
    endcase
    sx = longint'(width_q) * x;
    sy = longint'(height_q) * y;
    cr = cosine_of_turn(ra);
    sr = sine_of_turn(ra);
    rx = rnd_away(sx * cr - sy * sr, 2 * ptg_pkg::TRIG_FRAC_BITS) + pan_off_q;
    ry = rnd_away(sy * cr + sx * sr, 2 * ptg_pkg::TRIG_FRAC_BITS) + tilt_off_q;
    return {degrees_to_dmx(rx, pan_trav_q), degrees_to_dmx(ry, tilt_trav_q)};
  endfunction

  // write one register and mirror it
  task automatic write_reg(ptg_pkg::reg_idx_t idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ptg_pkg::REG_SHAPE: shape_q = val[2:0];
      ptg_pkg::REG_WIDTH: width_q = val[8:0];
      ptg_pkg::REG_HEIGHT: height_q = val[8:0];
      ptg_pkg::REG_PAN_OFFSET: pan_off_q = val[8:0];
      ptg_pkg::REG_TILT_OFFSET: tilt_off_q = val[8:0];
      ptg_pkg::REG_PAN_TRAVEL: pan_trav_q = val;
      default: tilt_trav_q = val;
    endcase
  endtask

  task automatic wait_idle();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // send one sample beat; valid held until accepted
  task automatic send_sample(logic [11:0] ph, logic [8:0] rot);
    in_valid <= 1'b1;
    phase <= ph;
    rotation <= rot;
    expected_bytes.push_back(predict_pan_tilt(ph, rot));
    do @(posedge clk); while (!in_ready);
  endtask

  int burst_left = 0;

  task automatic send_paced(logic [11:0] ph, logic [8:0] rot);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    send_sample(ph, rot);
    burst_left--;
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic configure(logic [2:0] shp, logic [8:0] w, logic [8:0] h,
                           logic [8:0] po, logic [8:0] tofs, logic [9:0] pt,
                           logic [9:0] tt);
    wait_idle();
    write_reg(ptg_pkg::REG_SHAPE, 10'(shp));
    write_reg(ptg_pkg::REG_WIDTH, 10'(w));
    write_reg(ptg_pkg::REG_HEIGHT, 10'(h));
    write_reg(ptg_pkg::REG_PAN_OFFSET, 10'(po));
    write_reg(ptg_pkg::REG_TILT_OFFSET, 10'(tofs));
    write_reg(ptg_pkg::REG_PAN_TRAVEL, pt);
    write_reg(ptg_pkg::REG_TILT_TRAVEL, tt);
  endtask

  // each shape code, also the two unused ones, at phase and rotation corners, 90 by 60, no offsets
  task automatic test_directed();
    logic [11:0] phs[6];
    phs = '{12'd0, 12'd1024, 12'd2048, 12'd3072, 12'd4095, 12'd1};
    for (int s = 0; s < 8; s++) begin
      configure(3'(s), 9'd90, 9'd60, 9'd0, 9'd0, 10'd360, 10'd150);
      for (int i = 0; i < 3; i++) send_sample(phs[$urandom_range(0, 5)], 9'd0);
      send_sample(12'd512, 9'd360);
      send_sample(12'd3000, 9'd511);
      end_stream();
    end
  endtask

  // extremes: large scale, max offsets, travel 0 and max, clamping both ends
  task automatic test_extremes();
    configure(ptg_pkg::SHAPE_CIRCLE, 9'd511, 9'd511, 9'h0ff, 9'h100, 10'd0, 10'd1023);
    send_sample(12'hfff, 9'd359);
    send_sample(12'h000, 9'd180);
    end_stream();
    configure(ptg_pkg::SHAPE_SQUARE, 9'd360, 9'd0, 9'h14c, 9'd180, 10'd720, 10'd1);
    send_sample(12'h7ff, 9'd45);
    send_sample(12'h800, 9'd270);
    end_stream();
    // full pause: wait for every result before resuming
    wait_idle();
    send_sample(12'haaa, 9'h155);
    end_stream();
  endtask

  // random samples over several random settings
  task automatic test_random();
    for (int p = 0; p < 10; p++) begin
      configure(3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)),
                9'($urandom_range(0, 511)),
                9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                p == 0 ? 10'd1023 : 10'($urandom_range(0, 720)),
                p == 1 ? 10'd0 : 10'($urandom_range(0, 1023)));
      stall_enable = (p % 3) != 2;
      for (int i = 0; i < 62; i++)
        send_paced(12'($urandom_range(0, 4095)), 9'($urandom_range(0, 511)));
      end_stream();
    end
    stall_enable = 1'b1;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !stall_enable || ($urandom_range(0, 9) > 2);
  end

  // result checker
  always @(posedge clk) begin
    logic [15:0] exp_b;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat pan=%0d tilt=%0d", pan_value, tilt_value);
      end else begin
        exp_b = expected_bytes.pop_front();
        if (pan_value !== exp_b[15:8] || tilt_value !== exp_b[7:0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch pan exp %0d got %0d, tilt exp %0d got %0d",
                     exp_b[15:8], pan_value, exp_b[7:0], tilt_value);
        end
      end
    end
  end

  initial begin
    shape_q = ptg_pkg::SHAPE_CIRCLE;
    width_q = 9'd30;
    height_q = 9'd30;
    pan_off_q = '0;
    tilt_off_q = '0;
    pan_trav_q = 10'd360;
    tilt_trav_q = 10'd150;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset defaults first
    send_sample(12'd0, 9'd0);
    send_sample(12'd1365, 9'd90);
    end_stream();
    test_directed();
    test_extremes();
    test_random();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end
endmodule
